// ----- hdl/slfd_pkg.sv -----
// Shared types and constants for the sync/length frame deframer.
// No dependencies; imported by the top level, slfd_parse and slfd_outq.
package slfd_pkg;

  // Default width of the wrapping frame and error counters.
  localparam int COUNT_WIDTH_DEF = 32;

  // Width of the counter fields carried on each result beat.
  localparam int OUT_COUNT_W = 32;

  // Output queue depth (power of two); one item can push up to two beats.
  localparam int QUEUE_DEPTH = 4;

  // Parser phase codes.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SYNC_VALUE = 2'd0;
  localparam logic [1:0] REG_MIN_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] SYNC_VALUE_RST = 8'd170;
  localparam logic [7:0] MIN_LENGTH_RST = 8'd1;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd255;

  // One result beat.
  typedef struct packed {
    logic [7:0]             frame_byte;
    logic                   frame_first;
    logic                   frame_last;
    logic [OUT_COUNT_W-1:0] frames_done;
    logic [OUT_COUNT_W-1:0] length_errors;
  } result_t;

  // Beats produced by one accepted byte, written to the queue together.
  typedef struct packed {
    logic [1:0] count;
    result_t    beat0;
    result_t    beat1;
  } push_t;

endpackage

// ----- hdl/sync_length_frame_deframer_top.sv -----
// Top level of the sync-byte, length-prefixed frame deframer.
// Depends on slfd_pkg, slfd_parse and slfd_outq.
//
// Usage:
// The in_ channel carries one received link byte per beat. The block hunts
// for the sync byte, checks the following length byte against the min and
// max registers, and on success emits two beats (the sync byte, marked
// first, and the length byte), then length+1 more beats, the last marked.
// A rejected length byte only bumps the length error counter. Each out_
// beat also carries the frame and length error counts as they stand after
// the byte that produced it.
// A byte accepted at an edge is written into the four-entry output queue at that
// edge; with the queue empty, its first result beat shows on the out_ ports right
// after that edge. One input beat is taken per cycle while in_ready is high; the
// queue absorbs the extra beat produced by the length byte.
// in_ready stays high while at least two queue entries are free, so with
// out_ready held high the block never stalls its sender.
// When the receiver stalls, the queue fills and in_ready drops; beats wait
// in order and none are lost. Reset (synchronous, active low) empties the
// queue, returns to hunting, clears both counters and loads the register
// defaults. Configuration writes take effect at the next edge.
module sync_length_frame_deframer_top #(
  parameter int COUNT_WIDTH = slfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_first,
  output logic        out_frame_last,
  output logic [31:0] out_frames_done,
  output logic [31:0] out_length_errors,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import slfd_pkg::*;

  logic [7:0] sync_value_r, sync_value_nxt;
  logic [7:0] min_length_r, min_length_nxt;
  logic [7:0] max_length_r, max_length_nxt;
  logic       in_accept;
  logic       room2;
  push_t      push;
  result_t    out_beat;

  // Configuration write decode; an unknown index is ignored.
  always_comb begin
    sync_value_nxt = sync_value_r;
    min_length_nxt = min_length_r;
    max_length_nxt = max_length_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_VALUE: sync_value_nxt = cfg_wdata;
        REG_MIN_LENGTH: min_length_nxt = cfg_wdata;
        REG_MAX_LENGTH: max_length_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_VALUE_RST;
      min_length_r <= MIN_LENGTH_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else begin
      sync_value_r <= sync_value_nxt;
      min_length_r <= min_length_nxt;
      max_length_r <= max_length_nxt;
    end
  end

  // Input side is ready whenever the queue can take the worst case of two beats.
  assign in_ready  = room2;
  assign in_accept = in_valid && in_ready;

  slfd_parse #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .sync_value (sync_value_r),
    .min_length (min_length_r),
    .max_length (max_length_r),
    .push       (push)
  );

  slfd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  assign out_frame_byte    = out_beat.frame_byte;
  assign out_frame_first   = out_beat.frame_first;
  assign out_frame_last    = out_beat.frame_last;
  assign out_frames_done   = out_beat.frames_done;
  assign out_length_errors = out_beat.length_errors;

endmodule

// ----- hdl/slfd_parse.sv -----
// Byte parser of the deframer: sync hunt, length check, frame streaming.
// Depends on slfd_pkg; produces up to two result beats per accepted byte.
module slfd_parse #(
  parameter int COUNT_WIDTH = slfd_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         sync_value,
  input  logic [7:0]         min_length,
  input  logic [7:0]         max_length,
  output slfd_pkg::push_t    push
);
  import slfd_pkg::*;

  logic [1:0]             phase_r, phase_nxt;
  logic [8:0]             rem_r, rem_nxt;
  logic [8:0]             rem_dec;
  logic [COUNT_WIDTH-1:0] fcnt_r, fcnt_nxt;
  logic [COUNT_WIDTH-1:0] ecnt_r, ecnt_nxt;
  logic [7:0]             held_r, held_nxt;

  assign rem_dec = rem_r - 9'd1;

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    fcnt_nxt  = fcnt_r;
    ecnt_nxt  = ecnt_r;
    held_nxt  = held_r;
    push      = '0;
    if (accept) begin
      unique case (phase_r)
        PH_LEN: begin
          if ((rx_byte < min_length) || (rx_byte > max_length)) begin
            ecnt_nxt  = ecnt_r + COUNT_WIDTH'(1);
            phase_nxt = PH_HUNT;
          end else begin
            rem_nxt                 = {1'b0, rx_byte} + 9'd1;
            phase_nxt               = PH_DATA;
            push.count              = 2'd2;
            push.beat0.frame_byte   = held_r;
            push.beat0.frame_first  = 1'b1;
            push.beat1.frame_byte   = rx_byte;
          end
        end
        PH_DATA: begin
          rem_nxt               = rem_dec;
          push.count            = 2'd1;
          push.beat0.frame_byte = rx_byte;
          if (rem_dec == 9'd0) begin
            fcnt_nxt              = fcnt_r + COUNT_WIDTH'(1);
            phase_nxt             = PH_HUNT;
            push.beat0.frame_last = 1'b1;
          end
        end
        default: begin
          // Hunting; the unused phase code behaves the same way.
          phase_nxt = PH_HUNT;
          if (rx_byte == sync_value) begin
            held_nxt  = rx_byte;
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
    push.beat0.frames_done   = OUT_COUNT_W'(fcnt_nxt);
    push.beat0.length_errors = OUT_COUNT_W'(ecnt_nxt);
    push.beat1.frames_done   = OUT_COUNT_W'(fcnt_nxt);
    push.beat1.length_errors = OUT_COUNT_W'(ecnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      rem_r   <= '0;
      fcnt_r  <= '0;
      ecnt_r  <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      fcnt_r  <= fcnt_nxt;
      ecnt_r  <= ecnt_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- hdl/slfd_outq.sv -----
// Small output queue of the deframer: takes up to two beats per cycle,
// hands out one beat per cycle while out_ready is high. Depends on slfd_pkg.
module slfd_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  slfd_pkg::push_t   push,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output slfd_pkg::result_t out_beat
);
  import slfd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic             pop;

  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_beat  = mem[rd_ptr_r];
  assign room2     = (count_r <= CNT_W'(QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.beat0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.beat1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/slfd_checker.sv -----
// Port-level checker for the deframer, with its bind to the top level.
// Depends only on the top level's ports.
module slfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_frame_byte,
  input logic        out_frame_first,
  input logic        out_frame_last,
  input logic [31:0] out_frames_done,
  input logic [31:0] out_length_errors
);

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=>
      out_valid && $stable(out_frame_byte) && $stable(out_frame_first) &&
      $stable(out_frame_last) && $stable(out_frames_done) &&
      $stable(out_length_errors))
    else $error("stalled out beat changed");

  // A waiting input beat keeps its byte until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("waiting in beat changed");

  // The sync beat is never also the last beat of a frame.
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_frame_first && out_frame_last))
    else $error("beat marked both first and last");

  // The length beat is queued with the sync beat, so it follows at once.
  a_len_follows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_ready && out_frame_first |=>
      out_valid && !out_frame_first)
    else $error("length beat missing after sync beat");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind sync_length_frame_deframer_top slfd_checker u_slfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_frame_byte    (out_frame_byte),
  .out_frame_first   (out_frame_first),
  .out_frame_last    (out_frame_last),
  .out_frames_done   (out_frames_done),
  .out_length_errors (out_length_errors)
);
